[src/assert_macros.svh]
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

[src/gmr_pkg.sv]
`default_nettype none
package gmr_pkg;

    localparam int SLOT_COUNT_DEF    = 5;
    localparam int ID_COUNT_DEF      = 4;
    localparam int DOUBLE_TAP_RADIUS = 40;
    localparam int QUEUE_DEPTH       = 2;

    localparam int RAW_W      = 16;
    localparam int POS_W      = 12;
    localparam int TIME_W     = 32;
    localparam int DIST_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_DOWN = 2'd1,
        OP_MOVE = 2'd2,
        OP_UP   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        EV_DOWN         = 4'd0,
        EV_DOUBLE_TAP   = 4'd1,
        EV_PINCH_BEGIN  = 4'd2,
        EV_PINCH_UPDATE = 4'd3,
        EV_PINCH_END    = 4'd4,
        EV_PAN_BEGIN    = 4'd5,
        EV_PAN_UPDATE   = 4'd6,
        EV_LONG_PRESS   = 4'd7,
        EV_TAP          = 4'd8,
        EV_PAN_END      = 4'd9,
        EV_UP           = 4'd10
    } ev_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SURFACE_WIDTH    = 3'd0,
        CFG_SURFACE_HEIGHT   = 3'd1,
        CFG_PAN_DEADZONE     = 3'd2,
        CFG_SWIPE_THRESHOLD  = 3'd3,
        CFG_JITTER_THRESHOLD = 3'd4,
        CFG_PINCH_DEADZONE   = 3'd5,
        CFG_TAP_TIMEOUT      = 3'd6,
        CFG_LONG_PRESS_TIME  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] surface_width;
        logic [11:0] surface_height;
        logic [7:0]  pan_deadzone;
        logic [9:0]  swipe_threshold;
        logic [7:0]  jitter_threshold;
        logic [11:0] pinch_deadzone;
        logic [15:0] tap_timeout;
        logic [15:0] long_press_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        surface_width:    12'd390,
        surface_height:   12'd450,
        pan_deadzone:     8'd10,
        swipe_threshold:  10'd30,
        jitter_threshold: 8'd3,
        pinch_deadzone:   12'd10,
        tap_timeout:      16'd300,
        long_press_time:  16'd600
    };

    function automatic logic [POS_W-1:0] absdiff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

[src/gmr_fifo.sv]
`default_nettype none
module gmr_fifo import gmr_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

[src/gmr_front.sv]
`default_nettype none
module gmr_front import gmr_pkg::*; #(
    parameter  int ID_COUNT = ID_COUNT_DEF,
    localparam int IDW      = $clog2(ID_COUNT),
    localparam int QW       = 2 + IDW + 2 * POS_W + TIME_W
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cfg_t                     cfg,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [1:0]               s_opcode,
    input  wire logic [7:0]               s_contact_id,
    input  wire logic signed [RAW_W-1:0]  s_raw_x,
    input  wire logic signed [RAW_W-1:0]  s_raw_y,
    input  wire logic [TIME_W-1:0]        s_time_ms,
    output logic                          push_valid,
    input  wire logic                     push_ready,
    output logic [QW-1:0]                 push_data
);
    localparam int DVD_W = POS_W + FRAC_W;
    localparam int DCW   = $clog2(DVD_W);
    localparam int MUL_W = RAW_W - 1 + FRAC_W;

    typedef enum logic [2:0] {F_IDLE, F_PEAK, F_DIV, F_MUL, F_CLAMP, F_PUSH} fstate_t;

    fstate_t                  state_reg, state_next;
    logic                     ax_reg, ax_next;
    logic [1:0]               op_reg, op_next;
    logic [7:0]               id_reg, id_next;
    logic signed [RAW_W-1:0]  rx_reg, rx_next, ry_reg, ry_next;
    logic [TIME_W-1:0]        time_reg, time_next;
    logic signed [RAW_W-1:0]  peak_reg [2];
    logic signed [RAW_W-1:0]  peak_next [2];
    logic [FRAC_W-1:0]        fac_reg [2];
    logic [FRAC_W-1:0]        fac_next [2];
    logic [POS_W-1:0]         x_reg, x_next, y_reg, y_next;
    logic [MUL_W-1:0]         prod_reg, prod_next;
    logic [DVD_W-1:0]         dvd_reg, dvd_next;
    logic [RAW_W-1:0]         dvs_reg, dvs_next;
    logic [RAW_W-1:0]         rem_reg, rem_next;
    logic [FRAC_W-1:0]        quo_reg, quo_next;
    logic [DCW-1:0]           dcnt_reg, dcnt_next;

    logic signed [RAW_W-1:0]  v;
    logic [POS_W-1:0]         size, se, r;
    logic signed [RAW_W-1:0]  peak_new;
    logic signed [RAW_W:0]    peak_ext, size_ext, r_s;
    logic                     learn;
    logic [RAW_W:0]           trial;
    logic                     ge;
    logic [RAW_W-1:0]         rem_step;
    logic [FRAC_W-1:0]        quo_step;
    logic [FRAC_W-1:0]        fac_cur;

    assign s_tready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = {op_reg, id_reg[IDW-1:0], x_reg, y_reg, time_reg};

    assign v        = ax_reg ? ry_reg : rx_reg;
    assign size     = ax_reg ? cfg.surface_height : cfg.surface_width;
    assign se       = (size == '0) ? POS_W'(1) : size;
    assign fac_cur  = fac_reg[ax_reg];
    assign peak_new = (v > peak_reg[ax_reg]) ? v : peak_reg[ax_reg];
    assign peak_ext = {peak_new[RAW_W-1], peak_new};
    assign size_ext = $signed({5'b0, size});
    assign learn    = (peak_ext > size_ext) && (fac_cur == '0);
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_step = ge ? RAW_W'(trial - {1'b0, dvs_reg}) : trial[RAW_W-1:0];
    assign quo_step = {quo_reg[FRAC_W-2:0], ge};

    always_comb begin
        if (fac_cur != '0) begin
            r_s = v[RAW_W-1] ? '0 : $signed({2'b00, prod_reg[MUL_W-1:FRAC_W]});
        end else begin
            r_s = {v[RAW_W-1], v};
        end
        if (r_s[RAW_W]) begin
            r = '0;
        end else if (r_s >= $signed({5'b0, se})) begin
            r = se - POS_W'(1);
        end else begin
            r = r_s[POS_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        ax_next    = ax_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        time_next  = time_reg;
        peak_next  = peak_reg;
        fac_next   = fac_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        prod_next  = prod_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_opcode;
                    id_next    = s_contact_id;
                    rx_next    = s_raw_x;
                    ry_next    = s_raw_y;
                    time_next  = s_time_ms;
                    ax_next    = 1'b0;
                    state_next = F_PEAK;
                end
            end
            F_PEAK: begin
                peak_next[ax_reg] = peak_new;
                if (learn) begin
                    dvd_next   = {size, FRAC_W'(0)};
                    dvs_next   = RAW_W'(peak_new) + RAW_W'(1);
                    rem_next   = '0;
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = F_DIV;
                end else begin
                    state_next = F_MUL;
                end
            end
            F_DIV: begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                dvd_next  = dvd_reg << 1;
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(DVD_W - 1)) begin
                    fac_next[ax_reg] = quo_step;
                    state_next       = F_MUL;
                end
            end
            F_MUL: begin
                prod_next  = MUL_W'(v[RAW_W-2:0]) * MUL_W'(fac_cur);
                state_next = F_CLAMP;
            end
            F_CLAMP: begin
                if (ax_reg) begin
                    y_next = r;
                end else begin
                    x_next = r;
                end
                if (!ax_reg) begin
                    ax_next    = 1'b1;
                    state_next = F_PEAK;
                end else if (op_reg != OP_NONE && id_reg < 8'(ID_COUNT)) begin
                    state_next = F_PUSH;
                end else begin
                    state_next = F_IDLE;
                end
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            ax_reg    <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                peak_reg[i] <= '0;
                fac_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            peak_reg  <= peak_next;
            fac_reg   <= fac_next;
        end
        op_reg   <= op_next;
        id_reg   <= id_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        time_reg <= time_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        prod_reg <= prod_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dcnt_reg <= dcnt_next;
    end
endmodule
`default_nettype wire

[src/gmr_back.sv]
`default_nettype none
module gmr_back import gmr_pkg::*; #(
    parameter  int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter  int ID_COUNT   = ID_COUNT_DEF,
    localparam int IDW        = $clog2(ID_COUNT),
    localparam int QW         = 2 + IDW + 2 * POS_W + TIME_W
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire logic [QW-1:0]     pop_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [3:0]             m_event_code,
    output logic [POS_W-1:0]       m_pos_x,
    output logic [POS_W-1:0]       m_pos_y,
    output logic [DIST_W-1:0]      m_pinch_dist,
    output logic                   m_tlast
);
    localparam int SIW    = $clog2(SLOT_COUNT);
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int ROOT_W = 2 * (POS_W + 1);
    localparam int SQ_W   = 2 * POS_W;

    typedef enum logic [2:0] {B_IDLE, B_DECODE, B_SQX, B_SQY, B_ROOT, B_PINCH, B_SEND}
        bstate_t;

    bstate_t             state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [IDW-1:0]      id_reg, id_next;
    logic [POS_W-1:0]    x_reg, x_next, y_reg, y_next;
    logic [TIME_W-1:0]   t_reg, t_next;

    logic                map_vld_reg [ID_COUNT];
    logic                map_vld_next [ID_COUNT];
    logic [SIW-1:0]      map_slot_reg [ID_COUNT];
    logic [SIW-1:0]      map_slot_next [ID_COUNT];
    logic                act_reg [SLOT_COUNT];
    logic                act_next [SLOT_COUNT];
    logic [POS_W-1:0]    posx_reg [SLOT_COUNT];
    logic [POS_W-1:0]    posx_next [SLOT_COUNT];
    logic [POS_W-1:0]    posy_reg [SLOT_COUNT];
    logic [POS_W-1:0]    posy_next [SLOT_COUNT];
    logic [TIME_W-1:0]   down_reg [SLOT_COUNT];
    logic [TIME_W-1:0]   down_next [SLOT_COUNT];

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [TIME_W-1:0]   tap_time_reg, tap_time_next;
    logic [POS_W-1:0]    tap_x_reg, tap_x_next, tap_y_reg, tap_y_next;
    logic [1:0]          tap_cnt_reg, tap_cnt_next;
    logic                moved_reg, moved_next;
    logic                lpd_reg, lpd_next;
    logic [POS_W-1:0]    org_x_reg, org_x_next, org_y_reg, org_y_next;
    logic [DIST_W-1:0]   base_reg, base_next;

    ev_t                 res_reg [3];
    ev_t                 res_next [3];
    logic [1:0]          n_reg, n_next;
    logic [1:0]          idx_reg, idx_next;
    logic                upd_reg, upd_next;

    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [ROOT_W-1:0]   rn_reg, rn_next, res_root_reg, res_root_next, bit_reg, bit_next;

    logic                out_valid_reg, out_valid_next;
    ev_t                 out_code_reg, out_code_next;
    logic [POS_W-1:0]    out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic                out_last_reg, out_last_next;

    logic                free_ok, s_ok, alloc;
    logic [SIW-1:0]      free_slot, s;
    logic [1:0]          ne;
    logic                need_pinch;
    logic [CW-1:0]       cnt_n;
    logic [1:0]          tap_inc;
    logic                pan_past, moved_n, load;
    logic [POS_W-1:0]    adx, ady;
    logic [ROOT_W:0]     rb;
    logic [DIST_W-1:0]   d, delta;

    assign pop_ready    = (state_reg == B_IDLE);
    assign m_tvalid     = out_valid_reg;
    assign m_event_code = out_code_reg;
    assign m_pos_x      = out_x_reg;
    assign m_pos_y      = out_y_reg;
    assign m_pinch_dist = out_dist_reg;
    assign m_tlast      = out_last_reg;

    assign adx = absdiff(posx_reg[0], posx_reg[1]);
    assign ady = absdiff(posy_reg[0], posy_reg[1]);
    assign rb  = {1'b0, res_root_reg} + {1'b0, bit_reg};
    assign d   = DIST_W'(res_root_reg);
    assign delta = (d >= base_reg) ? (d - base_reg) : (base_reg - d);
    assign pan_past = (absdiff(x_reg, org_x_reg) > POS_W'(cfg.pan_deadzone)) ||
                      (absdiff(y_reg, org_y_reg) > POS_W'(cfg.pan_deadzone));
    assign load = (state_reg == B_SEND) && (!out_valid_reg || m_tready);

    always_comb begin
        free_ok   = 1'b0;
        free_slot = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (!act_reg[k]) begin
                free_ok   = 1'b1;
                free_slot = SIW'(k);
            end
        end
        alloc = 1'b0;
        s_ok  = 1'b0;
        s     = free_slot;
        if (map_vld_reg[id_reg]) begin
            s_ok = 1'b1;
            s    = map_slot_reg[id_reg];
        end else if (op_reg == OP_DOWN && free_ok) begin
            s_ok  = 1'b1;
            alloc = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        t_next        = t_reg;
        map_vld_next  = map_vld_reg;
        map_slot_next = map_slot_reg;
        act_next      = act_reg;
        posx_next     = posx_reg;
        posy_next     = posy_reg;
        down_next     = down_reg;
        cnt_next      = cnt_reg;
        tap_time_next = tap_time_reg;
        tap_x_next    = tap_x_reg;
        tap_y_next    = tap_y_reg;
        tap_cnt_next  = tap_cnt_reg;
        moved_next    = moved_reg;
        lpd_next      = lpd_reg;
        org_x_next    = org_x_reg;
        org_y_next    = org_y_reg;
        base_next     = base_reg;
        res_next      = res_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        upd_next      = upd_reg;
        sq_next       = sq_reg;
        rn_next       = rn_reg;
        res_root_next = res_root_reg;
        bit_next      = bit_reg;
        out_code_next = out_code_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_dist_next = out_dist_reg;
        out_last_next = out_last_reg;
        ne            = '0;
        need_pinch    = 1'b0;
        cnt_n         = cnt_reg;
        tap_inc       = '0;
        moved_n       = moved_reg;

        unique case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    op_next    = op_t'(pop_data[QW-1 -: 2]);
                    id_next    = pop_data[QW-3 -: IDW];
                    x_next     = pop_data[2*POS_W+TIME_W-1 -: POS_W];
                    y_next     = pop_data[POS_W+TIME_W-1 -: POS_W];
                    t_next     = pop_data[TIME_W-1:0];
                    state_next = B_DECODE;
                end
            end
            B_DECODE: begin
                if (s_ok) begin
                    unique case (op_reg)
                        OP_DOWN: begin
                            if (alloc) begin
                                map_vld_next[id_reg]  = 1'b1;
                                map_slot_next[id_reg] = s;
                            end
                            posx_next[s] = x_reg;
                            posy_next[s] = y_reg;
                            if (act_reg[s]) begin
                                if (cnt_reg == CW'(1) && pan_past) begin
                                    res_next[0] = EV_PAN_BEGIN;
                                    res_next[1] = EV_PAN_UPDATE;
                                    ne          = 2'd2;
                                    org_x_next  = x_reg;
                                    org_y_next  = y_reg;
                                end
                            end else begin
                                act_next[s]  = 1'b1;
                                down_next[s] = t_reg;
                                cnt_n        = cnt_reg + CW'(1);
                                cnt_next     = cnt_n;
                                if (cnt_n == CW'(1)) begin
                                    if ((t_reg - tap_time_reg) < TIME_W'(cfg.tap_timeout) &&
                                        absdiff(x_reg, tap_x_reg) < POS_W'(DOUBLE_TAP_RADIUS) &&
                                        absdiff(y_reg, tap_y_reg) < POS_W'(DOUBLE_TAP_RADIUS))
                                    begin
                                        tap_inc = tap_cnt_reg + 2'd1;
                                        if (tap_inc >= 2'd2) begin
                                            res_next[ne] = EV_DOUBLE_TAP;
                                            ne           = ne + 2'd1;
                                            tap_cnt_next = '0;
                                        end else begin
                                            tap_cnt_next = tap_inc;
                                        end
                                    end else begin
                                        tap_cnt_next = '0;
                                    end
                                    tap_time_next = t_reg;
                                    tap_x_next    = x_reg;
                                    tap_y_next    = y_reg;
                                    moved_next    = 1'b0;
                                    lpd_next      = 1'b0;
                                    org_x_next    = x_reg;
                                    org_y_next    = y_reg;
                                    res_next[ne]  = EV_DOWN;
                                    ne            = ne + 2'd1;
                                end else if (cnt_n == CW'(2)) begin
                                    need_pinch = 1'b1;
                                    upd_next   = 1'b0;
                                end
                            end
                        end
                        OP_MOVE: begin
                            if (act_reg[s] &&
                                !(absdiff(x_reg, posx_reg[s]) < POS_W'(cfg.jitter_threshold) &&
                                  absdiff(y_reg, posy_reg[s]) < POS_W'(cfg.jitter_threshold)))
                            begin
                                posx_next[s] = x_reg;
                                posy_next[s] = y_reg;
                                if (cnt_reg >= CW'(2)) begin
                                    need_pinch = 1'b1;
                                    upd_next   = 1'b1;
                                end else if (cnt_reg == CW'(1)) begin
                                    if (pan_past) begin
                                        if (absdiff(x_reg, org_x_reg) >
                                                POS_W'(cfg.swipe_threshold) ||
                                            absdiff(y_reg, org_y_reg) >
                                                POS_W'(cfg.swipe_threshold)) begin
                                            moved_n = 1'b1;
                                        end
                                        if (!lpd_reg) begin
                                            res_next[ne] = EV_PAN_BEGIN;
                                            ne           = ne + 2'd1;
                                        end
                                        res_next[ne] = EV_PAN_UPDATE;
                                        ne           = ne + 2'd1;
                                        org_x_next   = x_reg;
                                        org_y_next   = y_reg;
                                    end
                                    moved_next = moved_n;
                                    if (!lpd_reg && !moved_n && (t_reg - down_reg[s]) >
                                            TIME_W'(cfg.long_press_time)) begin
                                        lpd_next     = 1'b1;
                                        res_next[ne] = EV_LONG_PRESS;
                                        ne           = ne + 2'd1;
                                    end
                                end
                            end
                        end
                        OP_UP: begin
                            if (act_reg[s]) begin
                                act_next[s]          = 1'b0;
                                cnt_n                = (cnt_reg != '0) ? cnt_reg - CW'(1)
                                                                       : cnt_reg;
                                cnt_next             = cnt_n;
                                map_vld_next[id_reg] = 1'b0;
                                if (cnt_n == '0) begin
                                    for (int i = 0; i < ID_COUNT; i++) begin
                                        map_vld_next[i] = 1'b0;
                                    end
                                end
                                if (cnt_n == CW'(1)) begin
                                    res_next[0] = EV_PINCH_END;
                                    ne          = 2'd1;
                                end else if (cnt_n == '0) begin
                                    if (!lpd_reg && !moved_reg &&
                                        absdiff(x_reg, tap_x_reg) <=
                                            POS_W'(cfg.swipe_threshold) &&
                                        absdiff(y_reg, tap_y_reg) <=
                                            POS_W'(cfg.swipe_threshold)) begin
                                        res_next[ne] = EV_TAP;
                                        ne           = ne + 2'd1;
                                    end
                                    if (lpd_reg) begin
                                        res_next[ne] = EV_PAN_END;
                                        ne           = ne + 2'd1;
                                    end
                                    res_next[ne] = EV_UP;
                                    ne           = ne + 2'd1;
                                end
                            end
                        end
                        OP_NONE: ;
                    endcase
                end
                n_next   = ne;
                idx_next = '0;
                if (need_pinch) begin
                    state_next = B_SQX;
                end else if (ne != '0) begin
                    state_next = B_SEND;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_SQX: begin
                sq_next    = SQ_W'(adx) * SQ_W'(adx);
                state_next = B_SQY;
            end
            B_SQY: begin
                rn_next       = ROOT_W'(sq_reg) + ROOT_W'(SQ_W'(ady) * SQ_W'(ady));
                res_root_next = '0;
                bit_next      = ROOT_W'(1) << (ROOT_W - 2);
                state_next    = B_ROOT;
            end
            B_ROOT: begin
                if ({1'b0, rn_reg} >= rb) begin
                    rn_next       = rn_reg - ROOT_W'(rb);
                    res_root_next = (res_root_reg >> 1) + bit_reg;
                end else begin
                    res_root_next = res_root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == ROOT_W'(1)) begin
                    state_next = B_PINCH;
                end
            end
            B_PINCH: begin
                if (!upd_reg) begin
                    base_next   = d;
                    res_next[0] = EV_PINCH_BEGIN;
                    n_next      = 2'd1;
                    state_next  = B_SEND;
                end else if (delta > DIST_W'(cfg.pinch_deadzone)) begin
                    base_next   = d;
                    res_next[0] = EV_PINCH_UPDATE;
                    n_next      = 2'd1;
                    state_next  = B_SEND;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_SEND: begin
                if (load) begin
                    out_code_next = res_reg[idx_reg];
                    out_x_next    = x_reg;
                    out_y_next    = y_reg;
                    out_last_next = (idx_reg == n_reg - 2'd1);
                    case (res_reg[idx_reg]) inside
                        EV_PINCH_BEGIN, EV_PINCH_UPDATE, EV_PINCH_END: out_dist_next = base_reg;
                        default: out_dist_next = '0;
                    endcase
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == n_reg - 2'd1) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ID_COUNT; i++) begin
                map_vld_reg[i]  <= 1'b0;
                map_slot_reg[i] <= '0;
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
                act_reg[i]  <= 1'b0;
                posx_reg[i] <= '0;
                posy_reg[i] <= '0;
                down_reg[i] <= '0;
            end
            cnt_reg      <= '0;
            tap_time_reg <= '0;
            tap_x_reg    <= '0;
            tap_y_reg    <= '0;
            tap_cnt_reg  <= '0;
            moved_reg    <= 1'b0;
            lpd_reg      <= 1'b0;
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            base_reg     <= '0;
            n_reg        <= '0;
            idx_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            map_vld_reg   <= map_vld_next;
            map_slot_reg  <= map_slot_next;
            act_reg       <= act_next;
            posx_reg      <= posx_next;
            posy_reg      <= posy_next;
            down_reg      <= down_next;
            cnt_reg       <= cnt_next;
            tap_time_reg  <= tap_time_next;
            tap_x_reg     <= tap_x_next;
            tap_y_reg     <= tap_y_next;
            tap_cnt_reg   <= tap_cnt_next;
            moved_reg     <= moved_next;
            lpd_reg       <= lpd_next;
            org_x_reg     <= org_x_next;
            org_y_reg     <= org_y_next;
            base_reg      <= base_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
        end
        op_reg       <= op_next;
        id_reg       <= id_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        t_reg        <= t_next;
        res_reg      <= res_next;
        upd_reg      <= upd_next;
        sq_reg       <= sq_next;
        rn_reg       <= rn_next;
        res_root_reg <= res_root_next;
        bit_reg      <= bit_next;
        out_code_reg <= out_code_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_dist_reg <= out_dist_next;
        out_last_reg <= out_last_next;
    end
endmodule
`default_nettype wire

[src/multitouch_gesture_recognizer.sv]
// Channel  Dir  Handshake          Fields (lowest bit up)
// s_       in   tvalid/tready      tuser: opcode; tdata: contact_id, raw_x, raw_y, time_ms
// m_       out  tvalid/tready      tuser: event_code; tdata: pos_x, pos_y, pinch_dist;
//                                  tlast: last
// cfg_     in   cfg_wr_en          cfg_addr: register index; cfg_wr_data: value
//
// Front: per request, peak, multiply and clamp per axis, then queue push; the first
//   request that fixes an axis scale factor adds a divide for that axis (restoring divider,
//   one quotient bit a cycle).
// Back: decode, then the events are sent one by one; a new request waits until all are sent.
//   Pinch events add two squares, a 13-step square root and a compare.
// Reset is synchronous, active low, and clears all gesture state at once.
// A 2-entry queue parts front and back; the output register holds a stalled event.
`default_nettype none
`include "assert_macros.svh"
module multitouch_gesture_recognizer import gmr_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int ID_COUNT   = ID_COUNT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [1:0]            s_tuser,   // opcode[1:0]
    input  wire logic [71:0]           s_tdata,   // contact_id[7:0], raw_x[23:8],
                                                  // raw_y[39:24], time_ms[71:40]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [3:0]                 m_tuser,   // event_code[3:0]
    output logic [39:0]                m_tdata,   // pos_x[11:0], pos_y[23:12],
                                                  // pinch_dist[39:24]
    output logic                       m_tlast
);
    localparam int IDW = $clog2(ID_COUNT);
    localparam int QW  = 2 + IDW + 2 * POS_W + TIME_W;

    cfg_t              cfg_reg;
    logic              q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    logic [QW-1:0]     q_push_data, q_pop_data;
    logic [POS_W-1:0]  pos_x, pos_y;
    logic [DIST_W-1:0] pinch_dist;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SURFACE_WIDTH:    cfg_reg.surface_width    <= cfg_wr_data[11:0];
                CFG_SURFACE_HEIGHT:   cfg_reg.surface_height   <= cfg_wr_data[11:0];
                CFG_PAN_DEADZONE:     cfg_reg.pan_deadzone     <= cfg_wr_data[7:0];
                CFG_SWIPE_THRESHOLD:  cfg_reg.swipe_threshold  <= cfg_wr_data[9:0];
                CFG_JITTER_THRESHOLD: cfg_reg.jitter_threshold <= cfg_wr_data[7:0];
                CFG_PINCH_DEADZONE:   cfg_reg.pinch_deadzone   <= cfg_wr_data[11:0];
                CFG_TAP_TIMEOUT:      cfg_reg.tap_timeout      <= cfg_wr_data;
                CFG_LONG_PRESS_TIME:  cfg_reg.long_press_time  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    gmr_front #(.ID_COUNT(ID_COUNT)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_opcode    (s_tuser),
        .s_contact_id(s_tdata[7:0]),
        .s_raw_x     (s_tdata[23:8]),
        .s_raw_y     (s_tdata[39:24]),
        .s_time_ms   (s_tdata[71:40]),
        .push_valid  (q_push_valid),
        .push_ready  (q_push_ready),
        .push_data   (q_push_data)
    );

    gmr_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(q_push_valid),
        .push_ready(q_push_ready),
        .push_data (q_push_data),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data)
    );

    gmr_back #(.SLOT_COUNT(SLOT_COUNT), .ID_COUNT(ID_COUNT)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .pop_valid   (q_pop_valid),
        .pop_ready   (q_pop_ready),
        .pop_data    (q_pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_event_code(m_tuser),
        .m_pos_x     (pos_x),
        .m_pos_y     (pos_y),
        .m_pinch_dist(pinch_dist),
        .m_tlast     (m_tlast)
    );

    assign m_tdata = {pinch_dist, pos_y, pos_x};

    `ASSERT_NEXT(a_push_hold, aclk, aresetn, q_push_valid && !q_push_ready, q_push_valid, "front dropped a queued request")
    `ASSERT_CLKD(a_push_op, aclk, aresetn, q_push_valid |-> (q_push_data[QW-1 -: 2] != OP_NONE), "empty request entered the queue")
    `ASSERT_CLKD(a_dist_pinch, aclk, aresetn, (m_tvalid && m_tdata[39:24] != 16'd0) |-> (m_tuser == EV_PINCH_BEGIN || m_tuser == EV_PINCH_UPDATE || m_tuser == EV_PINCH_END), "distance on a non-pinch event")
endmodule
`default_nettype wire
